// ===== hdl/ctc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared constants, codes and types of the capability table checker.
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CHECK  = 2'd2;
   localparam logic [1:0] CMD_REVOKE = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_INVAL = 3'd1;
   localparam logic [2:0] ST_NOENT = 3'd2;
   localparam logic [2:0] ST_PERM  = 3'd3;
   localparam logic [2:0] ST_NOMEM = 3'd4;
   localparam logic [2:0] ST_NOOBJ = 3'd5;

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   // One slot as kept in the table memory.
   typedef struct packed {
      logic [31:0] token_gen;
      logic [31:0] object_gen;
      logic [7:0]  obj_type;
      logic [63:0] rights;
      logic [63:0] object_ref;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic load;    // capture a request word and start the table read
      logic commit;  // evaluate, update the table and load the response
   } ctrl_cmd_type;

endpackage

// ===== hdl/ctc_if.sv =====
// ----------------------------------------------------------------------------
// ctc_req_if / ctc_rsp_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface ctc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] token;
   logic [63:0] object_ref;
   logic [63:0] rights_mask;
   logic [7:0]  required_type;
   logic        obj_found;
   logic [31:0] obj_generation;
   logic [7:0]  obj_type;

   modport source (output valid, cmd, token, object_ref, rights_mask, required_type,
                   obj_found, obj_generation, obj_type, input ready);
   modport sink   (input valid, cmd, token, object_ref, rights_mask, required_type,
                   obj_found, obj_generation, obj_type, output ready);
endinterface

interface ctc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] new_token;
   logic [63:0] entry_object;
   logic [63:0] entry_rights;
   logic [7:0]  entry_type;

   modport source (output valid, status, new_token, entry_object, entry_rights,
                   entry_type, input ready);
   modport sink   (input valid, status, new_token, entry_object, entry_rights,
                   entry_type, output ready);
endinterface

// ===== hdl/ctc_ram.sv =====
// ----------------------------------------------------------------------------
// ctc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/ctc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctc_ctrl
// Sequencer: takes a request word, waits for the table read, then commits
// once the response register is free.
// ----------------------------------------------------------------------------
module ctc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ctc_pkg::ctrl_cmd_type cmd
);
   import ctc_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_EVAL: begin
            cmd.commit = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== hdl/ctc_dp.sv =====
// ----------------------------------------------------------------------------
// ctc_dp
// Datapath: slot state vectors, slot memory, token validation and the
// response register.
// ----------------------------------------------------------------------------
module ctc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ctc_pkg::ctrl_cmd_type cmd,
   input  logic [1:0]            req_cmd,
   input  logic [63:0]           req_token,
   input  logic [63:0]           req_object_ref,
   input  logic [63:0]           req_rights_mask,
   input  logic [7:0]            req_required_type,
   input  logic                  req_obj_found,
   input  logic [31:0]           req_obj_generation,
   input  logic [7:0]            req_obj_type,
   output logic [2:0]            rsp_status,
   output logic [63:0]           rsp_new_token,
   output logic [63:0]           rsp_entry_object,
   output logic [63:0]           rsp_entry_rights,
   output logic [7:0]            rsp_entry_type
);
   import ctc_pkg::*;

   // Per-slot flags: occupied, revoked, and generation written at least once.
   logic [NUM_SLOTS-1:0] occ_ff, occ_in;
   logic [NUM_SLOTS-1:0] rev_ff, rev_in;
   logic [NUM_SLOTS-1:0] genv_ff, genv_in;

   // Captured request word.
   logic [1:0]  cmd_ff;
   logic [63:0] token_ff, object_ff, rights_ff;
   logic [7:0]  etype_ff, otype_ff;
   logic        found_ff;
   logic [31:0] ogen_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic        free_any_ff, free_any_in;

   logic [2:0]  status_ff, status_in;
   logic [63:0] ntok_ff, ntok_in, eobj_ff, eobj_in, erig_ff, erig_in;
   logic [7:0]  etyp_ff, etyp_in;

   logic [NUM_SLOTS-1:0] free_vec;
   logic [IDX_W-1:0]     free_idx;
   slot_type             rd, wr;
   logic                 we;
   logic [31:0]          cur_gen, bump_gen, tok_gen;
   logic                 in_range, bad_slot, ok;

   // Lowest free slot: empty or revoked.
   always_comb begin
      free_vec = ~occ_ff | rev_ff;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (free_vec[i]) free_idx = IDX_W'(i);
      end
      free_any_in = |free_vec;
      idx_in = (req_cmd == CMD_CREATE) ? free_idx : req_token[IDX_W-1:0];
   end

   ctc_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_slots (
      .clock (clock),
      .we    (we),
      .waddr (idx_ff),
      .wdata (wr),
      .re    (cmd.load),
      .raddr (idx_in),
      .rdata (rd)
   );

   always_comb begin
      cur_gen  = genv_ff[idx_ff] ? rd.token_gen : 32'd0;
      bump_gen = cur_gen + 32'd1;
      if (bump_gen == 32'd0) bump_gen = 32'd1;
      tok_gen  = token_ff[63:32];
      in_range = token_ff[31:0] < 32'(NUM_SLOTS);
      bad_slot = !in_range || tok_gen == 32'd0 || cur_gen != tok_gen ||
                 !occ_ff[idx_ff] || rev_ff[idx_ff];

      status_in = ST_OK;
      if (cmd_ff == CMD_CREATE) begin
         priority if (rights_ff == 64'd0) status_in = ST_INVAL;
         else if (!found_ff || object_ff == 64'd0) status_in = ST_NOOBJ;
         else if (!free_any_ff) status_in = ST_NOMEM;
      end else begin
         priority if (cmd_ff == CMD_CHECK && rights_ff == 64'd0) status_in = ST_INVAL;
         else if (token_ff == 64'd0) status_in = ST_INVAL;
         else if (bad_slot) status_in = ST_NOENT;
         else if (!found_ff) status_in = ST_NOOBJ;
         else if (ogen_ff != rd.object_gen || otype_ff != rd.obj_type) status_in = ST_NOENT;
         else if (cmd_ff == CMD_CHECK && etype_ff != 8'd0 && etype_ff != rd.obj_type)
            status_in = ST_PERM;
         else if (cmd_ff == CMD_CHECK && (rd.rights & rights_ff) != rights_ff)
            status_in = ST_PERM;
      end
      ok = status_in == ST_OK;

      ntok_in = 64'd0;
      eobj_in = 64'd0;
      erig_in = 64'd0;
      etyp_in = 8'd0;
      wr      = rd;
      we      = 1'b0;
      occ_in  = occ_ff;
      rev_in  = rev_ff;
      genv_in = genv_ff;
      if (cmd_ff == CMD_CREATE) begin
         wr.token_gen  = bump_gen;
         wr.object_gen = ogen_ff;
         wr.obj_type   = otype_ff;
         wr.rights     = rights_ff;
         wr.object_ref = object_ff;
         if (ok) begin
            ntok_in = {bump_gen, 32'(idx_ff)};
            eobj_in = object_ff;
            erig_in = rights_ff;
            etyp_in = otype_ff;
            we      = cmd.commit;
            if (cmd.commit) begin
               occ_in[idx_ff]  = 1'b1;
               rev_in[idx_ff]  = 1'b0;
               genv_in[idx_ff] = 1'b1;
            end
         end
      end else if (ok) begin
         eobj_in = rd.object_ref;
         erig_in = rd.rights;
         etyp_in = rd.obj_type;
         if (cmd_ff == CMD_REVOKE) begin
            wr.token_gen = bump_gen;
            we           = cmd.commit;
            if (cmd.commit) rev_in[idx_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         rev_ff  <= '0;
         genv_ff <= '0;
      end else begin
         occ_ff  <= occ_in;
         rev_ff  <= rev_in;
         genv_ff <= genv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff      <= req_cmd;
         token_ff    <= req_token;
         object_ff   <= req_object_ref;
         rights_ff   <= req_rights_mask;
         etype_ff    <= req_required_type;
         found_ff    <= req_obj_found;
         ogen_ff     <= req_obj_generation;
         otype_ff    <= req_obj_type;
         idx_ff      <= idx_in;
         free_any_ff <= free_any_in;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         ntok_ff   <= ntok_in;
         eobj_ff   <= eobj_in;
         erig_ff   <= erig_in;
         etyp_ff   <= etyp_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_new_token    = ntok_ff;
   assign rsp_entry_object = eobj_ff;
   assign rsp_entry_rights = erig_ff;
   assign rsp_entry_type   = etyp_ff;

endmodule

// ===== hdl/capability_table_checker.sv =====
// ----------------------------------------------------------------------------
// capability_table_checker
// Generational capability table with create, lookup, check and revoke.
// ----------------------------------------------------------------------------
// For each request word, the lowest free slot (for create) or the token's slot
// index is first selected and the slot memory is read; then the token is
// validated, the slot is updated on create and revoke, and the response word
// is loaded. The registered read of the slot memory is followed by its
// read-modify-write, and one request is worked on at a time. A request can be
// taken while the previous response word still waits; the evaluation then
// holds until that response is taken. No clearing pass is needed after reset,
// since occupancy, revoked and generation flags live in flip-flops that reset
// clears.
module capability_table_checker (
   input  logic       clock,
   input  logic       reset,
   ctc_req_if.sink    req_if,
   ctc_rsp_if.source  rsp_if
);
   import ctc_pkg::*;

   ctrl_cmd_type cmd;

   // The sequencer owns the handshakes.
   ctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // The datapath holds the table and builds the response word.
   ctc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_cmd            (req_if.cmd),
      .req_token          (req_if.token),
      .req_object_ref     (req_if.object_ref),
      .req_rights_mask    (req_if.rights_mask),
      .req_required_type  (req_if.required_type),
      .req_obj_found      (req_if.obj_found),
      .req_obj_generation (req_if.obj_generation),
      .req_obj_type       (req_if.obj_type),
      .rsp_status         (rsp_if.status),
      .rsp_new_token      (rsp_if.new_token),
      .rsp_entry_object   (rsp_if.entry_object),
      .rsp_entry_rights   (rsp_if.entry_rights),
      .rsp_entry_type     (rsp_if.entry_type)
   );

endmodule

// ===== hdl/ctc_checker.sv =====
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level assertions for the capability table checker.
// ----------------------------------------------------------------------------
module ctc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [63:0] rsp_new_token,
   input logic [63:0] rsp_entry_object,
   input logic [63:0] rsp_entry_rights
);
   import ctc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_new_token == 64'd0 &&
      rsp_entry_object == 64'd0 && rsp_entry_rights == 64'd0)
      else $error("failed response carries entry data");

   a_ok_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_entry_object != 64'd0 &&
      rsp_entry_rights != 64'd0)
      else $error("successful response with an empty entry");

endmodule

bind capability_table_checker ctc_checker u_ctc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_new_token    (rsp_if.new_token),
   .rsp_entry_object (rsp_if.entry_object),
   .rsp_entry_rights (rsp_if.entry_rights)
);
